[hdl/ipv4_header_receive_check_core_macros.svh]
// Assertion helpers shared by the header check RTL.
`ifndef IPV4_HEADER_RECEIVE_CHECK_CORE_MACROS_SVH
`define IPV4_HEADER_RECEIVE_CHECK_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[hdl/ihrc_pkg.sv]
`timescale 1ns / 1ps

package ihrc_pkg;

   // Header geometry
   localparam logic [4:0] HDR_BYTES     = 5'd20;
   localparam logic [4:0] HDR_LAST_BYTE = 5'd19;
   localparam logic [4:0] TTL_BYTE      = 5'd8;
   localparam logic [4:0] ADDR_BYTE     = 5'd12;
   localparam logic [15:0] SUM_GOOD     = 16'hFFFF;

   // Protocol numbers
   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   // Control register indexes
   localparam logic [1:0] CSR_LOCAL_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_UDP_ENABLE    = 2'd1;
   localparam logic [1:0] CSR_TCP_ENABLE    = 2'd2;

   typedef enum logic [2:0] {
      VERDICT_BAD_SUM   = 3'd0,
      VERDICT_NOT_LOCAL = 3'd1,
      VERDICT_ICMP      = 3'd2,
      VERDICT_UDP       = 3'd3,
      VERDICT_TCP       = 3'd4,
      VERDICT_UNHANDLED = 3'd5
   } verdict_type;

   typedef struct packed {
      logic [31:0] local_address;
      logic        udp_enable;
      logic        tcp_enable;
   } cfg_type;

   typedef struct packed {
      verdict_type verdict;
      logic [31:0] source_address;
      logic [7:0]  protocol_number;
      logic [3:0]  header_words;
      logic [15:0] total_length;
      logic [15:0] ident;
      logic [2:0]  frag_flags;
      logic [12:0] frag_offset;
      logic [7:0]  time_to_live;
      logic [7:0]  service_byte;
      logic [3:0]  ip_version;
   } rsp_type;

endpackage

[hdl/ihrc_channels.sv]
`timescale 1ns / 1ps

// Header byte stream channel
interface ihrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] header_byte;
   logic       start_of_header;

   modport source (output valid, output header_byte, output start_of_header, input ready);
   modport sink (input valid, input header_byte, input start_of_header, output ready);
endinterface

// Verdict channel
interface ihrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  verdict;
   logic [31:0] source_address;
   logic [7:0]  protocol_number;
   logic [3:0]  header_words;
   logic [15:0] total_length;
   logic [15:0] ident;
   logic [2:0]  frag_flags;
   logic [12:0] frag_offset;
   logic [7:0]  time_to_live;
   logic [7:0]  service_byte;
   logic [3:0]  ip_version;

   modport source (output valid, output verdict, output source_address,
                   output protocol_number, output header_words, output total_length,
                   output ident, output frag_flags, output frag_offset,
                   output time_to_live, output service_byte, output ip_version,
                   input ready);
   modport sink (input valid, input verdict, input source_address,
                 input protocol_number, input header_words, input total_length,
                 input ident, input frag_flags, input frag_offset,
                 input time_to_live, input service_byte, input ip_version,
                 output ready);
endinterface

// Control register write channel
interface ihrc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/ipv4_header_receive_check_core.sv]
`timescale 1ns / 1ps
`include "ipv4_header_receive_check_core_macros.svh"

// IPv4 header receive check. Takes one header byte per item (start_of_header marks byte 0),
// sums the 16-bit words of the first 20 bytes in ones' complement and captures the fields;
// after byte 19 it emits one verdict with the parsed fields (bytes past 19 give nothing until
// the next start mark). It accepts one byte every cycle; a byte waits in the input register
// only when it completes a header while the result register still holds a verdict that the
// sink has not taken. The last byte passes from the input register into the parse logic, which
// loads the verdict into the result register, and the verdict is presented from there. Control
// registers: index 0 local address, 1 UDP enable, 2 TCP enable; write them only while no header
// is in flight.
module ipv4_header_receive_check_core
   import ihrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ihrc_req_if.sink   req_if,
   ihrc_rsp_if.source rsp_if,
   ihrc_csr_if.sink   csr_if
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_start_ff, in_start_in;
   cfg_type    cfg_ff, cfg_in;
   logic       advance;
   logic       rsp_free;
   logic       parse_last;
   logic       req_take;
   logic       csr_take;
   logic       parse_done;
   rsp_type    parse_result;

   // Input register: advance unless a finished header finds the result slot full
   always_comb begin
      advance      = in_valid_ff && (rsp_free || !parse_last);
      req_if.ready = !in_valid_ff || advance;
      req_take     = req_if.valid && req_if.ready;
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_byte_in   = req_take ? req_if.header_byte : in_byte_ff;
      in_start_in  = req_take ? req_if.start_of_header : in_start_ff;
   end

   // Control register writes
   always_comb begin
      csr_if.ready = 1'b1;
      csr_take     = csr_if.valid;
      cfg_in       = cfg_ff;
      if (csr_take) begin
         case (csr_if.index)
            CSR_LOCAL_ADDRESS: cfg_in.local_address = csr_if.data;
            CSR_UDP_ENABLE:    cfg_in.udp_enable    = csr_if.data[0];
            CSR_TCP_ENABLE:    cfg_in.tcp_enable    = csr_if.data[0];
            default:           cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cfg_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         cfg_ff      <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_start_ff <= in_start_in;
   end

   ihrc_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .step_byte  (in_byte_ff),
      .step_start (in_start_ff),
      .cfg        (cfg_ff),
      .last_byte  (parse_last),
      .done       (parse_done),
      .result     (parse_result)
   );

   ihrc_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (parse_done),
      .load_data (parse_result),
      .free      (rsp_free),
      .rsp_if    (rsp_if)
   );

   `ASSERT_IMPL(a_load_when_free, clock, reset, parse_done, rsp_free && in_valid_ff)
   `ASSERT_NEXT(a_input_held, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff) && $stable(in_start_ff))
   `ASSERT_NEXT(a_local_written, clock, reset, csr_if.valid && (csr_if.index == CSR_LOCAL_ADDRESS), cfg_ff.local_address == $past(csr_if.data))

endmodule

[hdl/ihrc_parse.sv]
`timescale 1ns / 1ps
`include "ipv4_header_receive_check_core_macros.svh"

module ihrc_parse
   import ihrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_valid,
   input  logic [7:0] step_byte,
   input  logic       step_start,
   input  cfg_type    cfg,
   output logic       last_byte,
   output logic       done,
   output rsp_type    result
);

   logic [4:0]  byte_count_ff, byte_count_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  high_byte_ff, high_byte_in;
   logic [63:0] field_ff, field_in;
   logic [15:0] ttl_proto_ff, ttl_proto_in;
   logic [63:0] address_ff, address_in;

   logic [4:0]  count_eff;
   logic [15:0] sum_eff;
   logic        active;
   logic [16:0] sum_added;
   logic [15:0] sum_fold;
   logic [31:0] dst_address;
   logic [7:0]  proto;
   verdict_type verdict;

   // Restart count and sum on a start mark, then fold in the current byte
   always_comb begin
      count_eff    = step_start ? '0 : byte_count_ff;
      sum_eff      = step_start ? '0 : sum_ff;
      active       = step_valid && (count_eff < HDR_BYTES);
      sum_added    = {1'b0, sum_eff} + {1'b0, high_byte_ff, step_byte};
      sum_fold     = sum_added[16] ? (sum_added[15:0] + 16'd1) : sum_added[15:0];

      byte_count_in = byte_count_ff;
      sum_in        = sum_ff;
      high_byte_in  = high_byte_ff;
      field_in      = field_ff;
      ttl_proto_in  = ttl_proto_ff;
      address_in    = address_ff;
      if (active) begin
         byte_count_in = count_eff + 5'd1;
         sum_in        = sum_eff;
         if (!count_eff[0]) begin
            high_byte_in = step_byte;
         end else begin
            sum_in = sum_fold;
         end
         if (count_eff < TTL_BYTE) begin
            field_in = {field_ff[55:0], step_byte};
         end else if (count_eff < (TTL_BYTE + 5'd2)) begin
            ttl_proto_in = {ttl_proto_ff[7:0], step_byte};
         end else if (count_eff >= ADDR_BYTE) begin
            address_in = {address_ff[55:0], step_byte};
         end
      end
   end

   // Build the verdict on the last header byte
   always_comb begin
      last_byte   = (count_eff == HDR_LAST_BYTE);
      done        = active && last_byte;
      dst_address = {address_ff[23:0], step_byte};
      proto       = ttl_proto_ff[7:0];
      if (sum_fold != SUM_GOOD) begin
         verdict = VERDICT_BAD_SUM;
      end else if (dst_address != cfg.local_address) begin
         verdict = VERDICT_NOT_LOCAL;
      end else if (proto == PROTO_ICMP) begin
         verdict = VERDICT_ICMP;
      end else if ((proto == PROTO_UDP) && cfg.udp_enable) begin
         verdict = VERDICT_UDP;
      end else if ((proto == PROTO_TCP) && cfg.tcp_enable) begin
         verdict = VERDICT_TCP;
      end else begin
         verdict = VERDICT_UNHANDLED;
      end

      result.verdict         = verdict;
      result.source_address  = address_ff[55:24];
      result.protocol_number = proto;
      result.header_words    = field_ff[59:56];
      result.total_length    = field_ff[47:32];
      result.ident           = field_ff[31:16];
      result.frag_flags      = field_ff[15:13];
      result.frag_offset     = field_ff[12:0];
      result.time_to_live    = ttl_proto_ff[15:8];
      result.service_byte    = field_ff[55:48];
      result.ip_version      = field_ff[63:60];
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         sum_ff        <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         sum_ff        <= sum_in;
      end
   end

   // Capture header fields
   always_ff @(posedge clock) begin
      high_byte_ff <= high_byte_in;
      field_ff     <= field_in;
      ttl_proto_ff <= ttl_proto_in;
      address_ff   <= address_in;
   end

   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, byte_count_ff <= HDR_BYTES)
   `ASSERT_NEXT(a_done_count, clock, reset, done, byte_count_ff == HDR_BYTES)
   `ASSERT_NEXT(a_tail_ignored, clock, reset, step_valid && !step_start && (byte_count_ff == HDR_BYTES), $stable(sum_ff) && (byte_count_ff == HDR_BYTES))

endmodule

[hdl/ihrc_rsp_reg.sv]
`timescale 1ns / 1ps

module ihrc_rsp_reg
   import ihrc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    free,
   ihrc_rsp_if.source rsp_if
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // Slot frees when empty or when the sink takes the item this cycle
   always_comb begin
      free     = !valid_ff || rsp_if.ready;
      valid_in = load ? 1'b1 : (free ? 1'b0 : valid_ff);
      data_in  = load ? load_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // Drive the result channel
   assign rsp_if.valid           = valid_ff;
   assign rsp_if.verdict         = data_ff.verdict;
   assign rsp_if.source_address  = data_ff.source_address;
   assign rsp_if.protocol_number = data_ff.protocol_number;
   assign rsp_if.header_words    = data_ff.header_words;
   assign rsp_if.total_length    = data_ff.total_length;
   assign rsp_if.ident           = data_ff.ident;
   assign rsp_if.frag_flags      = data_ff.frag_flags;
   assign rsp_if.frag_offset     = data_ff.frag_offset;
   assign rsp_if.time_to_live    = data_ff.time_to_live;
   assign rsp_if.service_byte    = data_ff.service_byte;
   assign rsp_if.ip_version      = data_ff.ip_version;

endmodule
